@@ rtl/sbdlt_pkg.sv @@
// package for the serial bus device listener/talker
// holds bus line codes, phase codes, port bit positions and command constants
`timescale 1ns / 1ps
package sbdlt_pkg;

   localparam int AtnOutPos  = 3;
   localparam int ClkOutPos  = 4;
   localparam int DataOutPos = 5;
   localparam int ClkInPos   = 1;
   localparam int DataInPos  = 2;

   localparam logic [7:0] OutMask = 8'((1 << AtnOutPos) | (1 << ClkOutPos) | (1 << DataOutPos));
   localparam logic [7:0] InMask  = 8'((1 << ClkInPos) | (1 << DataInPos));

   // line bits
   localparam logic [2:0] L_ATN  = 3'b001;
   localparam logic [2:0] L_CLK  = 3'b010;
   localparam logic [2:0] L_DATA = 3'b100;

   typedef enum logic [1:0] {
      ACT_PORT_WR = 2'd0,
      ACT_DIR_WR  = 2'd1,
      ACT_TICK    = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ROLE_IDLE   = 2'd0,
      ROLE_LISTEN = 2'd1,
      ROLE_TALK   = 2'd2
   } role_type;

   typedef enum logic [1:0] {
      RX_IDLE     = 2'd0,
      RX_WAIT_CLK = 2'd1,
      RX_READY    = 2'd2,
      RX_BITS     = 2'd3
   } rx_phase_type;

   typedef enum logic [3:0] {
      TX_IDLE      = 4'd0,
      TX_INITIAL   = 4'd1,
      TX_READY     = 4'd2,
      TX_BIT_SETUP = 4'd3,
      TX_BIT_VALID = 4'd4,
      TX_BIT_END   = 4'd5,
      TX_BYTE_END  = 4'd6,
      TX_HOLD      = 4'd7,
      TX_ALL_SENT  = 4'd8
   } tx_phase_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_REOPEN   = 3'd1,
      EV_OPEN     = 3'd2,
      EV_CLOSE    = 3'd3,
      EV_UNLISTEN = 3'd4
   } event_type;

   localparam logic [2:0] CSR_ADDR    = 3'd0;
   localparam logic [2:0] CSR_SETTLE  = 3'd1;
   localparam logic [2:0] CSR_ACK     = 3'd2;
   localparam logic [2:0] CSR_EOIHOLD = 3'd3;
   localparam logic [2:0] CSR_EOIDET  = 3'd4;
   localparam logic [2:0] CSR_TIMEOUT = 3'd5;

   localparam logic [7:0] CMD_LISTEN_LO = 8'h20;
   localparam logic [7:0] CMD_LISTEN_HI = 8'h3E;
   localparam logic [7:0] CMD_UNLISTEN  = 8'h3F;
   localparam logic [7:0] CMD_TALK_LO   = 8'h40;
   localparam logic [7:0] CMD_TALK_HI   = 8'h5E;
   localparam logic [7:0] CMD_UNTALK    = 8'h5F;
   localparam logic [3:0] CMD_REOPEN    = 4'h6;
   localparam logic [3:0] CMD_CLOSE     = 4'hE;
   localparam logic [3:0] CMD_OPEN      = 4'hF;
   localparam logic [7:0] NO_CHANNEL    = 8'hFF;
   localparam logic [16:0] EoiTimerMax  = 17'h1FFFF;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  port_value;
      logic [7:0]  dir_value;
      logic [15:0] tick_cycles;
      logic [7:0]  read_base;
      logic [7:0]  next_talk_byte;
      logic        next_talk_valid;
      logic        next_talk_last;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clk_level;
      logic       data_level;
      logic [1:0] bus_role;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       rx_last;
      logic       talk_taken;
      logic [2:0] channel_event;
      logic [3:0] channel_number;
   } rsp_type;

endpackage

@@ rtl/sbdlt_stream_if.sv @@
// valid/ready channel carrying one payload beat
// depends on sbdlt_pkg for the payload types
`timescale 1ns / 1ps
interface sbdlt_req_if;
   import sbdlt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sbdlt_rsp_if;
   import sbdlt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/serial_bus_device_listener_talker.sv @@
// Device side of a three-wire open-collector serial bus (ATN, CLK, DATA).
// Each accepted req beat (port write, direction write, tick or port read) is
// fully handled combinationally, registered, and gives exactly one rsp beat; a
// new beat is taken every cycle while the single rsp register is free or being
// drained. Throughput is one beat per clock unless rsp stalls; the state update
// path (edge handling chained with the command decode) sets the cycle time.
// depends on sbdlt_pkg and the sbdlt stream interfaces
`timescale 1ns / 1ps
module serial_bus_device_listener_talker
   import sbdlt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sbdlt_req_if.sink   req,
   sbdlt_rsp_if.source rsp,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   // configuration
   logic [4:0]  dev_addr_ff;
   logic [15:0] settle_ff, ack_ff, eoi_hold_ff, eoi_det_ff, timeout_ff;

   // protocol state
   role_type     role_ff, role_in;
   rx_phase_type rx_phase_ff, rx_phase_in;
   logic [3:0]   rx_cnt_ff, rx_cnt_in;
   logic [7:0]   rx_shift_ff, rx_shift_in;
   logic         rx_eoi_ff, rx_eoi_in;
   logic [16:0]  rx_timer_ff, rx_timer_in;
   tx_phase_type tx_phase_ff, tx_phase_in;
   logic [3:0]   tx_idx_ff, tx_idx_in;
   logic [7:0]   tx_shift_ff, tx_shift_in;
   logic         tx_eoi_ff, tx_eoi_in;
   logic [17:0]  tx_delay_ff, tx_delay_in;
   logic [7:0]   port_ff, port_in, dir_ff, dir_in;
   logic [2:0]   prev_ff, prev_in;
   logic [7:0]   sec_ff, sec_in;
   logic         open_ff, open_in;
   logic [2:0]   host_ff, host_in, dev_ff, dev_in;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic accept;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   // per-beat update
   always_comb begin
      req_type    r;
      logic [7:0] act, b, rd;
      logic       atn_now, now_low, was_low, listening, dhigh, eoi, fetched;
      logic [16:0] tsum;
      logic [17:0] c;
      r = req.data;
      role_in = role_ff; rx_phase_in = rx_phase_ff; rx_cnt_in = rx_cnt_ff;
      rx_shift_in = rx_shift_ff; rx_eoi_in = rx_eoi_ff; rx_timer_in = rx_timer_ff;
      tx_phase_in = tx_phase_ff; tx_idx_in = tx_idx_ff; tx_shift_in = tx_shift_ff;
      tx_eoi_in = tx_eoi_ff; tx_delay_in = tx_delay_ff; port_in = port_ff;
      dir_in = dir_ff; prev_in = prev_ff; sec_in = sec_ff; open_in = open_ff;
      host_in = host_ff; dev_in = dev_ff;
      rsp_in = '0;
      act = '0; b = '0; rd = '0; atn_now = 1'b0; now_low = 1'b0; was_low = 1'b0;
      listening = 1'b0; dhigh = 1'b0; eoi = 1'b0; fetched = 1'b0; tsum = '0;
      c = {2'b00, r.tick_cycles};

      if (r.action == ACT_PORT_WR || r.action == ACT_DIR_WR) begin
         if (r.action == ACT_PORT_WR) port_in = r.port_value;
         else dir_in = r.dir_value;
         act = port_in & dir_in;
         atn_now = act[AtnOutPos];
         host_in = {act[DataOutPos], act[ClkOutPos], atn_now};
         // attention edges
         if (atn_now != prev_in[0]) begin
            if (atn_now) begin
               prev_in[0] = 1'b1;
               tx_phase_in = TX_IDLE;
               rx_phase_in = RX_WAIT_CLK;
               rx_cnt_in = '0; rx_shift_in = '0; rx_eoi_in = 1'b0;
               dev_in = (dev_in | L_DATA) & ~L_CLK;
               prev_in[2] = 1'b1;
            end else begin
               prev_in[0] = 1'b0;
               if (role_in == ROLE_TALK) begin
                  rx_phase_in = RX_IDLE;
                  tx_idx_in = '0;
                  if (r.next_talk_valid) begin
                     tx_shift_in = r.next_talk_byte; tx_eoi_in = r.next_talk_last;
                     rsp_in.talk_taken = 1'b1;
                     dev_in = (dev_in | L_CLK) & ~L_DATA;
                     tx_phase_in = TX_INITIAL; tx_delay_in = {2'b00, settle_ff};
                  end else begin
                     tx_shift_in = '0; tx_eoi_in = 1'b0; dev_in = '0;
                     tx_phase_in = TX_ALL_SENT; tx_delay_in = '0;
                  end
               end else if (role_in == ROLE_LISTEN) begin
                  rx_phase_in = RX_WAIT_CLK;
                  dev_in = (dev_in | L_DATA) & ~L_CLK;
               end else begin
                  dev_in = '0;
               end
            end
         end
         // clock line edges
         listening = (role_in == ROLE_LISTEN) || prev_in[0];
         now_low = |((host_in | dev_in) & L_CLK);
         was_low = prev_in[1];
         if (now_low != was_low) begin
            if (listening) begin
               if (!now_low) begin
                  if (rx_phase_in == RX_WAIT_CLK) begin
                     dev_in = dev_in & ~L_DATA;
                     rx_phase_in = RX_READY; rx_timer_in = '0;
                  end else if (rx_phase_in == RX_BITS && rx_cnt_in < 4'd8) begin
                     dhigh = ~|((host_in | dev_in) & L_DATA);
                     rx_shift_in[rx_cnt_in[2:0]] = rx_shift_in[rx_cnt_in[2:0]] | dhigh;
                     rx_cnt_in = rx_cnt_in + 4'd1;
                  end
               end else begin
                  if (rx_phase_in == RX_READY) begin
                     rx_phase_in = RX_BITS; rx_cnt_in = '0; rx_shift_in = '0;
                  end else if (rx_phase_in == RX_BITS && rx_cnt_in >= 4'd8) begin
                     b = rx_shift_in; eoi = rx_eoi_in;
                     dev_in = dev_in | L_DATA;
                     rx_shift_in = '0; rx_cnt_in = '0; rx_eoi_in = 1'b0;
                     rx_phase_in = RX_WAIT_CLK;
                     if (prev_in[0] && (!open_in || b == CMD_UNLISTEN
                           || b == CMD_UNTALK)) begin
                        // command decode
                        if (b >= CMD_LISTEN_LO && b <= CMD_LISTEN_HI) begin
                           role_in = (b[4:0] == dev_addr_ff) ? ROLE_LISTEN : ROLE_IDLE;
                        end else if (b == CMD_UNLISTEN) begin
                           if (open_in) begin
                              rsp_in.channel_event = EV_UNLISTEN;
                              rsp_in.channel_number = sec_in[3:0];
                              open_in = 1'b0;
                           end
                           if (role_in == ROLE_LISTEN) role_in = ROLE_IDLE;
                        end else if (b >= CMD_TALK_LO && b <= CMD_TALK_HI) begin
                           role_in = (b[4:0] == dev_addr_ff) ? ROLE_TALK : ROLE_IDLE;
                        end else if (b == CMD_UNTALK) begin
                           if (role_in == ROLE_TALK) role_in = ROLE_IDLE;
                        end else if (role_in == ROLE_LISTEN || role_in == ROLE_TALK) begin
                           if (b[7:4] == CMD_REOPEN) begin
                              sec_in = {4'h0, b[3:0]}; open_in = 1'b0;
                              rsp_in.channel_event = EV_REOPEN;
                              rsp_in.channel_number = b[3:0];
                           end else if (b[7:4] == CMD_CLOSE) begin
                              sec_in = NO_CHANNEL; open_in = 1'b0;
                              rsp_in.channel_event = EV_CLOSE;
                              rsp_in.channel_number = b[3:0];
                           end else if (b[7:4] == CMD_OPEN) begin
                              sec_in = {4'h0, b[3:0]}; open_in = 1'b1;
                              rsp_in.channel_event = EV_OPEN;
                              rsp_in.channel_number = b[3:0];
                           end
                        end
                     end else begin
                        rsp_in.rx_valid = 1'b1; rsp_in.rx_data = b; rsp_in.rx_last = eoi;
                     end
                  end
               end
            end
            prev_in[1] = now_low;
         end
         // data line edges
         now_low = |((host_in | dev_in) & L_DATA);
         was_low = prev_in[2];
         if (now_low != was_low) begin
            if (now_low && role_in == ROLE_TALK && tx_phase_in == TX_BYTE_END) begin
               tx_phase_in = TX_HOLD; tx_delay_in = {2'b00, ack_ff};
            end
            prev_in[2] = now_low;
         end
      end else if (r.action == ACT_TICK && r.tick_cycles != 16'd0) begin
         // listener eoi timer
         if (((role_ff == ROLE_LISTEN) || prev_ff[0]) && rx_phase_ff == RX_READY) begin
            tsum = ({1'b0, rx_timer_ff} + {2'b00, r.tick_cycles}) > {1'b0, EoiTimerMax}
               ? EoiTimerMax : rx_timer_ff + {1'b0, r.tick_cycles};
            rx_timer_in = tsum;
            if (tsum > {1'b0, eoi_det_ff}) rx_eoi_in = 1'b1;
         end
         // talker sequence
         if (role_ff == ROLE_TALK) begin
            if (tx_delay_ff > c) begin
               tx_delay_in = tx_delay_ff - c;
            end else begin
               tx_delay_in = '0;
               case (tx_phase_ff)
                  TX_INITIAL: begin
                     dev_in = dev_ff & ~(L_CLK | L_DATA);
                     tx_phase_in = TX_READY;
                     tx_delay_in = {2'b00, tx_eoi_ff ? eoi_hold_ff : settle_ff};
                  end
                  TX_READY: begin
                     dev_in = dev_ff | L_CLK; tx_idx_in = '0;
                     tx_phase_in = TX_BIT_SETUP; tx_delay_in = {2'b00, settle_ff};
                  end
                  TX_BIT_SETUP: begin
                     dev_in = dev_ff | L_CLK;
                     dev_in[2] = ~tx_shift_ff[tx_idx_ff[2:0]];
                     tx_phase_in = TX_BIT_VALID; tx_delay_in = {2'b00, settle_ff};
                  end
                  TX_BIT_VALID: begin
                     dev_in = dev_ff & ~L_CLK;
                     tx_phase_in = TX_BIT_END; tx_delay_in = {2'b00, settle_ff};
                  end
                  TX_BIT_END: begin
                     tx_idx_in = tx_idx_ff + 4'd1;
                     if (tx_idx_in >= 4'd8) begin
                        dev_in = dev_ff & ~(L_CLK | L_DATA);
                        tx_phase_in = TX_BYTE_END; tx_delay_in = '0;
                     end else begin
                        dev_in = dev_ff | L_CLK;
                        tx_phase_in = TX_BIT_SETUP; tx_delay_in = {2'b00, settle_ff};
                     end
                  end
                  TX_BYTE_END: begin
                     tx_delay_in = {2'b00, timeout_ff}; tx_phase_in = TX_HOLD;
                  end
                  TX_HOLD: begin
                     tx_idx_in = '0;
                     fetched = r.next_talk_valid;
                     if (fetched) begin
                        tx_shift_in = r.next_talk_byte; tx_eoi_in = r.next_talk_last;
                        rsp_in.talk_taken = 1'b1;
                        dev_in = (dev_ff | L_CLK) & ~L_DATA;
                        tx_phase_in = TX_INITIAL; tx_delay_in = {2'b00, settle_ff};
                     end else begin
                        tx_shift_in = '0; tx_eoi_in = 1'b0; dev_in = '0;
                        tx_phase_in = TX_ALL_SENT; tx_delay_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end

      // merged port read
      rd = r.read_base & ~(OutMask | InMask);
      rd[ClkInPos]  = ~|((host_in | dev_in) & L_CLK);
      rd[DataInPos] = ~|((host_in | dev_in) & L_DATA);
      rd = rd | (port_in & OutMask);
      rsp_in.read_data  = rd;
      rsp_in.clk_level  = rd[ClkInPos];
      rsp_in.data_level = rd[DataInPos];
      rsp_in.bus_role   = role_in;
   end

   // state, configuration and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff <= 5'd8; settle_ff <= 16'd30; ack_ff <= 16'd60;
         eoi_hold_ff <= 16'd250; eoi_det_ff <= 16'd205; timeout_ff <= 16'd1500;
         role_ff <= ROLE_IDLE; rx_phase_ff <= RX_IDLE; rx_cnt_ff <= '0;
         rx_shift_ff <= '0; rx_eoi_ff <= 1'b0; rx_timer_ff <= '0;
         tx_phase_ff <= TX_IDLE; tx_idx_ff <= '0; tx_shift_ff <= '0;
         tx_eoi_ff <= 1'b0; tx_delay_ff <= '0; port_ff <= '0; dir_ff <= '0;
         prev_ff <= '0; sec_ff <= NO_CHANNEL; open_ff <= 1'b0;
         host_ff <= '0; dev_ff <= '0; rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_ADDR:    dev_addr_ff <= csr_data[4:0];
               CSR_SETTLE:  settle_ff <= csr_data;
               CSR_ACK:     ack_ff <= csr_data;
               CSR_EOIHOLD: eoi_hold_ff <= csr_data;
               CSR_EOIDET:  eoi_det_ff <= csr_data;
               CSR_TIMEOUT: timeout_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            role_ff <= role_in; rx_phase_ff <= rx_phase_in; rx_cnt_ff <= rx_cnt_in;
            rx_shift_ff <= rx_shift_in; rx_eoi_ff <= rx_eoi_in;
            rx_timer_ff <= rx_timer_in; tx_phase_ff <= tx_phase_in;
            tx_idx_ff <= tx_idx_in; tx_shift_ff <= tx_shift_in; tx_eoi_ff <= tx_eoi_in;
            tx_delay_ff <= tx_delay_in; port_ff <= port_in; dir_ff <= dir_in;
            prev_ff <= prev_in; sec_ff <= sec_in; open_ff <= open_in;
            host_ff <= host_in; dev_ff <= dev_in;
            rsp_ff <= rsp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for serial_bus_device_listener_talker
// depends on sbdlt_pkg, the sbdlt stream interfaces and the rtl top
`timescale 1ns / 1ps
module tb_top;
   import sbdlt_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = CSR_ADDR;
   logic [15:0] csr_data = '0;

   sbdlt_req_if req_ch ();
   sbdlt_rsp_if rsp_ch ();

   serial_bus_device_listener_talker u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------
   // bus device model state
   logic [4:0]  m_addr;
   logic [15:0] m_settle, m_ack, m_eoi_hold, m_eoi_det, m_timeout;
   role_type     m_role;
   rx_phase_type m_rx;
   tx_phase_type m_tx;
   logic [3:0]  m_bits, m_tx_idx;
   logic [7:0]  m_rx_shift, m_tx_shift, m_port, m_dir, m_chan;
   logic        m_rx_eoi, m_tx_eoi, m_window;
   logic [16:0] m_eoi_timer;
   logic [17:0] m_delay;
   logic [2:0]  m_prev_low, m_host, m_dev;
   rsp_type     m_out;

   function automatic logic line_up(logic [2:0] line);
      return ((m_host | m_dev) & line) == 3'b000;
   endfunction

   function automatic void pull(logic [2:0] line, logic on);
      if (on) m_dev = m_dev | line;
      else m_dev = m_dev & ~line;
   endfunction

   function automatic logic is_listening();
      return m_role == ROLE_LISTEN || m_prev_low[0];
   endfunction

   function automatic logic take_talk_byte(req_type r);
      if (r.next_talk_valid) begin
         m_tx_shift = r.next_talk_byte;
         m_tx_eoi = r.next_talk_last;
         m_out.talk_taken = 1'b1;
         return 1'b1;
      end
      m_tx_shift = '0;
      m_tx_eoi = 1'b0;
      return 1'b0;
   endfunction

   // next byte or all sent
   function automatic void load_next_byte(req_type r);
      m_tx_idx = '0;
      if (take_talk_byte(r)) begin
         pull(L_CLK, 1'b1);
         pull(L_DATA, 1'b0);
         m_tx = TX_INITIAL;
         m_delay = 18'(m_settle);
      end else begin
         m_dev = '0;
         m_tx = TX_ALL_SENT;
         m_delay = '0;
      end
   endfunction

   function automatic void decode_command(logic [7:0] b);
      if (b >= CMD_LISTEN_LO && b <= CMD_LISTEN_HI) begin
         m_role = (b[4:0] == m_addr) ? ROLE_LISTEN : ROLE_IDLE;
      end else if (b == CMD_UNLISTEN) begin
         if (m_window) begin
            m_out.channel_event = EV_UNLISTEN;
            m_out.channel_number = m_chan[3:0];
            m_window = 1'b0;
         end
         if (m_role == ROLE_LISTEN) m_role = ROLE_IDLE;
      end else if (b >= CMD_TALK_LO && b <= CMD_TALK_HI) begin
         m_role = (b[4:0] == m_addr) ? ROLE_TALK : ROLE_IDLE;
      end else if (b == CMD_UNTALK) begin
         if (m_role == ROLE_TALK) m_role = ROLE_IDLE;
      end else if (m_role == ROLE_LISTEN || m_role == ROLE_TALK) begin
         if (b[7:4] == CMD_REOPEN) begin
            m_chan = {4'h0, b[3:0]};
            m_window = 1'b0;
            m_out.channel_event = EV_REOPEN;
            m_out.channel_number = b[3:0];
         end else if (b[7:4] == CMD_CLOSE) begin
            m_chan = NO_CHANNEL;
            m_window = 1'b0;
            m_out.channel_event = EV_CLOSE;
            m_out.channel_number = b[3:0];
         end else if (b[7:4] == CMD_OPEN) begin
            m_chan = {4'h0, b[3:0]};
            m_window = 1'b1;
            m_out.channel_event = EV_OPEN;
            m_out.channel_number = b[3:0];
         end
      end
   endfunction

   function automatic void clock_rise();
      if (!is_listening()) return;
      if (m_rx == RX_WAIT_CLK) begin
         pull(L_DATA, 1'b0);
         m_rx = RX_READY;
         m_eoi_timer = '0;
      end else if (m_rx == RX_BITS && m_bits < 4'd8) begin
         m_rx_shift[m_bits[2:0]] = m_rx_shift[m_bits[2:0]] | line_up(L_DATA);
         m_bits = m_bits + 4'd1;
      end
   endfunction

   function automatic void clock_fall();
      logic [7:0] b;
      logic e;
      if (!is_listening()) return;
      if (m_rx == RX_READY) begin
         m_rx = RX_BITS;
         m_bits = '0;
         m_rx_shift = '0;
      end else if (m_rx == RX_BITS && m_bits >= 4'd8) begin
         b = m_rx_shift;
         e = m_rx_eoi;
         pull(L_DATA, 1'b1);
         m_rx_shift = '0;
         m_bits = '0;
         m_rx_eoi = 1'b0;
         // under atn commands, except filename bytes after open (unlisten and untalk still decode)
         if (m_prev_low[0] && (!m_window || b == CMD_UNLISTEN || b == CMD_UNTALK)) begin
            decode_command(b);
         end else begin
            m_out.rx_valid = 1'b1;
            m_out.rx_data = b;
            m_out.rx_last = e;
         end
         m_rx = RX_WAIT_CLK;
      end
   endfunction

   function automatic void host_lines_changed(req_type r);
      logic [7:0] act;
      logic now_low;
      act = m_port & m_dir;
      m_host = {act[DataOutPos], act[ClkOutPos], act[AtnOutPos]};
      // atn edge
      if (act[AtnOutPos] != m_prev_low[0]) begin
         if (act[AtnOutPos]) begin
            m_prev_low[0] = 1'b1;
            m_tx = TX_IDLE;
            m_rx = RX_WAIT_CLK;
            m_bits = '0;
            m_rx_shift = '0;
            m_rx_eoi = 1'b0;
            pull(L_DATA, 1'b1);
            pull(L_CLK, 1'b0);
            m_prev_low[2] = ~line_up(L_DATA);
         end else begin
            m_prev_low[0] = 1'b0;
            if (m_role == ROLE_TALK) begin
               m_rx = RX_IDLE;
               load_next_byte(r);
            end else if (m_role == ROLE_LISTEN) begin
               m_rx = RX_WAIT_CLK;
               pull(L_DATA, 1'b1);
               pull(L_CLK, 1'b0);
            end else begin
               m_dev = '0;
            end
         end
      end
      // clk edge
      now_low = ~line_up(L_CLK);
      if (now_low != m_prev_low[1]) begin
         if (now_low) clock_fall();
         else clock_rise();
         m_prev_low[1] = now_low;
      end
      // data edge: listener ack of a talked byte
      now_low = ~line_up(L_DATA);
      if (now_low != m_prev_low[2]) begin
         if (now_low && m_role == ROLE_TALK && m_tx == TX_BYTE_END) begin
            m_tx = TX_HOLD;
            m_delay = 18'(m_ack);
         end
         m_prev_low[2] = now_low;
      end
   endfunction

   function automatic void advance_time(req_type r);
      logic [17:0] c;
      logic [17:0] sum;
      c = 18'(r.tick_cycles);
      if (c == 0) return;
      if (is_listening() && m_rx == RX_READY) begin
         sum = 18'(m_eoi_timer) + c;
         m_eoi_timer = (sum > 18'(EoiTimerMax)) ? EoiTimerMax : sum[16:0];
         if (m_eoi_timer > 17'(m_eoi_det)) m_rx_eoi = 1'b1;
      end
      if (m_role != ROLE_TALK) return;
      if (m_delay > c) begin
         m_delay = m_delay - c;
         return;
      end
      m_delay = '0;
      case (m_tx)
         TX_INITIAL: begin
            pull(L_CLK, 1'b0);
            pull(L_DATA, 1'b0);
            m_tx = TX_READY;
            m_delay = 18'(m_tx_eoi ? m_eoi_hold : m_settle);
         end
         TX_READY: begin
            pull(L_CLK, 1'b1);
            m_tx_idx = '0;
            m_tx = TX_BIT_SETUP;
            m_delay = 18'(m_settle);
         end
         TX_BIT_SETUP: begin
            pull(L_DATA, ~m_tx_shift[m_tx_idx[2:0]]);
            pull(L_CLK, 1'b1);
            m_tx = TX_BIT_VALID;
            m_delay = 18'(m_settle);
         end
         TX_BIT_VALID: begin
            pull(L_CLK, 1'b0);
            m_tx = TX_BIT_END;
            m_delay = 18'(m_settle);
         end
         TX_BIT_END: begin
            m_tx_idx = m_tx_idx + 4'd1;
            if (m_tx_idx >= 4'd8) begin
               pull(L_DATA, 1'b0);
               pull(L_CLK, 1'b0);
               m_tx = TX_BYTE_END;
               m_delay = '0;
            end else begin
               pull(L_CLK, 1'b1);
               m_tx = TX_BIT_SETUP;
               m_delay = 18'(m_settle);
            end
         end
         TX_BYTE_END: begin
            m_delay = 18'(m_timeout);
            m_tx = TX_HOLD;
         end
         TX_HOLD: load_next_byte(r);
         default: ;
      endcase
   endfunction

   function automatic rsp_type bus_step(req_type r);
      logic [7:0] rd;
      m_out = '0;
      case (action_type'(r.action))
         ACT_PORT_WR: begin
            m_port = r.port_value;
            host_lines_changed(r);
         end
         ACT_DIR_WR: begin
            m_dir = r.dir_value;
            host_lines_changed(r);
         end
         ACT_TICK: advance_time(r);
         default: ;
      endcase
      rd = r.read_base & ~(OutMask | InMask);
      rd[ClkInPos] = line_up(L_CLK);
      rd[DataInPos] = line_up(L_DATA);
      rd = rd | (m_port & OutMask);
      m_out.read_data = rd;
      m_out.clk_level = line_up(L_CLK);
      m_out.data_level = line_up(L_DATA);
      m_out.bus_role = m_role;
      return m_out;
   endfunction

   function automatic void device_reset();
      m_addr = 5'd8; m_settle = 16'd30; m_ack = 16'd60;
      m_eoi_hold = 16'd250; m_eoi_det = 16'd205; m_timeout = 16'd1500;
      m_role = ROLE_IDLE; m_rx = RX_IDLE; m_tx = TX_IDLE;
      m_bits = '0; m_tx_idx = '0; m_rx_shift = '0; m_tx_shift = '0;
      m_port = '0; m_dir = '0; m_chan = NO_CHANNEL;
      m_rx_eoi = 1'b0; m_tx_eoi = 1'b0; m_window = 1'b0;
      m_eoi_timer = '0; m_delay = '0; m_prev_low = '0; m_host = '0; m_dev = '0;
   endfunction

   function automatic void shadow_csr(logic [2:0] idx, logic [15:0] v);
      case (idx)
         CSR_ADDR:    m_addr = v[4:0];
         CSR_SETTLE:  m_settle = v;
         CSR_ACK:     m_ack = v;
         CSR_EOIHOLD: m_eoi_hold = v;
         CSR_EOIDET:  m_eoi_det = v;
         CSR_TIMEOUT: m_timeout = v;
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // stimulus, driver, monitor
   req_type pending_beats[$];
   rsp_type expected_rsp[$];
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      mismatches = 0;
   int      rsp_seen = 0;
   int      rx_bytes = 0;
   int      events_seen = 0;
   int      cycle_count = 0;

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.data <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) expected_rsp.push_back(bus_step(req_ch.data));
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_ch.valid <= 1'b1;
            req_ch.data <= pending_beats.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_seen++;
            if (rsp_ch.data.rx_valid) rx_bytes++;
            if (rsp_ch.data.channel_event != EV_NONE) events_seen++;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected rsp beat %p", rsp_ch.data);
            end else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_ch.data !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp mismatch #%0d\n  exp %p\n  got %p", rsp_seen, exp_r,
                        rsp_ch.data);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 2000000) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   function automatic req_type mk(action_type a, logic [7:0] pv, logic [7:0] dv,
                                  logic [15:0] tc);
      req_type r;
      r.action = a;
      r.port_value = pv;
      r.dir_value = dv;
      r.tick_cycles = tc;
      r.read_base = 8'($urandom);
      r.next_talk_byte = 8'($urandom);
      r.next_talk_valid = ($urandom_range(9) != 0);
      r.next_talk_last = 1'($urandom_range(1));
      return r;
   endfunction

   logic [7:0] host_port;
   int items_queued = 0;

   function automatic void push(req_type r);
      pending_beats.push_back(r);
      items_queued++;
   endfunction

   function automatic void port_wr(logic [7:0] v);
      host_port = v;
      push(mk(ACT_PORT_WR, v, 8'($urandom), 16'($urandom)));
   endfunction

   // host sends one byte: clk released, then pulled, 8 bits, clk pulled
   function automatic void host_byte(logic [7:0] b, logic long_wait);
      logic [7:0] p;
      p = host_port;
      p[ClkOutPos] = 1'b0;
      port_wr(p);
      if (long_wait || $urandom_range(3) == 0)
         push(mk(ACT_TICK, '0, '0, long_wait ? 16'($urandom_range(300, 65535))
                                              : 16'($urandom_range(0, 400))));
      p[ClkOutPos] = 1'b1;
      port_wr(p);
      for (int i = 0; i < 8; i++) begin
         p[DataOutPos] = ~b[i];
         p[ClkOutPos] = 1'b1;
         port_wr(p);
         p[ClkOutPos] = 1'b0;
         port_wr(p);
         if ($urandom_range(15) == 0) push(mk(ACT_READ, '0, '0, '0));
      end
      p[DataOutPos] = 1'b0;
      p[ClkOutPos] = 1'b1;
      port_wr(p);
   endfunction

   function automatic void set_atn(logic on);
      logic [7:0] p;
      p = host_port;
      p[AtnOutPos] = on;
      port_wr(p);
   endfunction

   function automatic logic [7:0] pick_command(logic [4:0] addr);
      logic [4:0] a;
      a = ($urandom_range(2) == 0) ? 5'($urandom_range(30)) : addr;
      case ($urandom_range(9))
         0: return {3'b001, a};
         1: return {3'b010, a};
         2: return CMD_UNLISTEN;
         3: return CMD_UNTALK;
         4: return {CMD_REOPEN, 4'($urandom)};
         5: return {CMD_CLOSE, 4'($urandom)};
         6: return {CMD_OPEN, 4'($urandom)};
         7: return ($urandom_range(1) == 0) ? {3'b001, addr} : {3'b010, addr};
         default: return 8'($urandom);
      endcase
   endfunction

   // one host transaction: atn, commands, release, then data, talk ticks or a random beat
   function automatic void bus_session(logic [4:0] addr);
      int n;
      set_atn(1'b1);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) host_byte(pick_command(addr), 1'b0);
      set_atn(1'b0);
      case ($urandom_range(2))
         0: begin
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) host_byte(8'($urandom), $urandom_range(4) == 0);
         end
         1: begin
            n = $urandom_range(5, 40);
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(4) == 0) begin
                  logic [7:0] p;
                  p = host_port;
                  p[DataOutPos] = ~p[DataOutPos];
                  port_wr(p);
               end else begin
                  push(mk(ACT_TICK, '0, '0, 16'($urandom_range(0, 80))));
               end
            end
         end
         default: push(mk(action_type'($urandom_range(3)), 8'($urandom), 8'($urandom),
                          16'($urandom)));
      endcase
   endfunction

   task automatic drain();
      while (pending_beats.size() > 0 || expected_rsp.size() > 0 || req_ch.valid)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // one register write, with csr_write dropped again before the next
   task automatic write_csr(logic [2:0] idx, logic [15:0] v);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      shadow_csr(idx, v);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(int n_items, int idle_pct, int stall_pct, logic [4:0] addr);
      int start;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      start = items_queued;
      while (items_queued - start < n_items) begin
         if ($urandom_range(9) == 0)
            push(mk(action_type'($urandom_range(3)), 8'($urandom), 8'($urandom),
                    16'($urandom)));
         else bus_session(addr);
      end
      drain();
   endtask

   initial begin
      logic [4:0] addr;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      host_port = '0;
      device_reset();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: direction setup, extremes, listen, open window
      push(mk(ACT_READ, '0, '0, '0));
      push(mk(ACT_TICK, '0, '0, 16'h0000));
      push(mk(ACT_TICK, '0, '0, 16'hFFFF));
      push(mk(ACT_DIR_WR, 8'hFF, 8'hFF, '0));
      push(mk(ACT_DIR_WR, 8'h00, 8'h00, '0));
      push(mk(ACT_PORT_WR, 8'hFF, 8'hFF, '0));
      push(mk(ACT_DIR_WR, 8'h00, 8'h38, '0));
      port_wr(8'h00);
      set_atn(1'b1);
      host_byte(8'h28, 1'b0);
      host_byte(8'hF3, 1'b0);
      host_byte(8'hA5, 1'b0);
      host_byte(CMD_UNLISTEN, 1'b0);
      set_atn(1'b0);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         addr = (ph == 0) ? 5'd8 : (ph == 1) ? 5'd0 : (ph == 2) ? 5'd30 : 5'($urandom_range(30));
         write_csr(CSR_ADDR, {11'd0, addr});
         write_csr(CSR_SETTLE, (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 60)));
         write_csr(CSR_ACK, (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 90)));
         write_csr(CSR_EOIHOLD, (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 300)));
         write_csr(CSR_EOIDET, (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 300)));
         write_csr(CSR_TIMEOUT, (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF : 16'($urandom_range(1, 2000)));
         run_phase(320, (ph == 1 || ph == 3) ? 73 : 0, (ph >= 2) ? 73 : 0, addr);
      end
      send_idle_pct = 32;
      recv_stall_pct = 32;
      run_phase(160, 32, 32, addr);

      $display("covered %0d beats: %0d data bytes received, %0d channel events",
               rsp_seen, rx_bytes, events_seen);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ serial_bus_device_listener_talker.f @@
rtl/sbdlt_pkg.sv
rtl/sbdlt_stream_if.sv
rtl/serial_bus_device_listener_talker.sv
verif/tb_top.sv
